[design/ess_pkg.sv]
// types, constants and helper functions for the elevator sweep scheduler
// no dependencies

package ess_pkg;

   localparam int FLOORS  = 16;
   localparam int FLOOR_W = 4;

   typedef logic [FLOORS-1:0]  floor_set_type;
   typedef logic [FLOOR_W-1:0] floor_type;

   typedef enum logic [1:0] {
      CMD_HALL  = 2'd0,
      CMD_CABIN = 2'd1,
      CMD_STEP  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOVE,
      ST_STATUS
   } state_type;

   typedef struct packed {
      logic load_req;
      logic do_step;
      logic show_move;
      logic advance;
   } dp_cmd_type;

   typedef struct packed {
      logic step_moves;
      logic at_target;
   } dp_status_type;

   function automatic floor_type lowest_bit(floor_set_type m);
      floor_type r;
      r = '0;
      for (int i = FLOORS - 1; i >= 0; i--) begin
         if (m[i]) begin
            r = FLOOR_W'(i);
         end
      end
      return r;
   endfunction

   function automatic floor_type highest_bit(floor_set_type m);
      floor_type r;
      r = '0;
      for (int i = 0; i < FLOORS; i++) begin
         if (m[i]) begin
            r = FLOOR_W'(i);
         end
      end
      return r;
   endfunction

endpackage

[design/ess_if.sv]
// request and result channel interfaces
// depends on ess_pkg

interface ess_req_if import ess_pkg::*; ();
   logic      valid;
   logic      ready;
   logic [1:0] cmd;
   floor_type floor;
   logic      dir;

   modport source (output valid, output cmd, output floor, output dir, input ready);
   modport sink (input valid, input cmd, input floor, input dir, output ready);
endinterface

interface ess_rsp_if import ess_pkg::*; ();
   logic      valid;
   logic      ready;
   floor_type car_floor;
   logic      car_dir;
   logic      idle;
   logic      last;

   modport source (output valid, output car_floor, output car_dir, output idle,
                   output last, input ready);
   modport sink (input valid, input car_floor, input car_dir, input idle,
                 input last, output ready);
endinterface

[design/ess_ctrl.sv]
// controller state machine: handshakes and sequencing of a step
// depends on ess_pkg

module ess_ctrl import ess_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_cmd,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    dp_cmd
);

   state_type state_ff, state_in;
   logic      req_xfer, rsp_xfer, is_step, is_req;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign is_step  = req_cmd == CMD_STEP;
   assign is_req   = (req_cmd == CMD_HALL) || (req_cmd == CMD_CABIN);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && is_step) begin
               state_in = status.step_moves ? ST_MOVE : ST_STATUS;
            end
         end
         ST_MOVE: begin
            if (rsp_xfer && status.at_target) begin
               state_in = ST_IDLE;
            end
         end
         ST_STATUS: begin
            if (rsp_xfer) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready        = 1'b0;
      rsp_valid        = 1'b0;
      dp_cmd.load_req  = 1'b0;
      dp_cmd.do_step   = 1'b0;
      dp_cmd.show_move = 1'b0;
      dp_cmd.advance   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            dp_cmd.load_req = req_xfer && is_req;
            dp_cmd.do_step  = req_xfer && is_step;
         end
         ST_MOVE: begin
            rsp_valid        = 1'b1;
            dp_cmd.show_move = 1'b1;
            dp_cmd.advance   = rsp_xfer;
         end
         ST_STATUS: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/ess_datapath.sv]
// datapath: request sets, car position, target selection and result fields
// depends on ess_pkg

module ess_datapath import ess_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    dp_cmd,
   input  logic [1:0]    req_cmd,
   input  floor_type     req_floor,
   input  logic          req_dir,
   output dp_status_type status,
   output floor_type     rsp_car_floor,
   output logic          rsp_car_dir,
   output logic          rsp_idle,
   output logic          rsp_last
);

   floor_set_type up_ff, up_in, down_ff, down_in;
   floor_set_type pup_ff, pup_in, pdn_ff, pdn_in;
   floor_type     floor_ff, floor_in, target_ff, target_in;
   logic          sweep_ff, sweep_in;

   floor_set_type req_bit;
   floor_type     next_floor, low_t, high_t;
   logic          eff_dir, req_in_range;

   assign req_in_range = 32'(req_floor) < FLOORS;
   assign req_bit      = floor_set_type'(1) << req_floor;
   assign eff_dir      = (req_cmd == CMD_CABIN) ? sweep_ff : req_dir;
   assign low_t        = lowest_bit(up_ff);
   assign high_t       = highest_bit(down_ff);
   assign next_floor   = sweep_ff ? floor_ff - floor_type'(1) : floor_ff + floor_type'(1);

   assign status.step_moves = sweep_ff ? ((down_ff != '0) && (high_t < floor_ff))
                                       : ((up_ff != '0) && (low_t > floor_ff));
   assign status.at_target  = next_floor == target_ff;

   assign rsp_car_floor = dp_cmd.show_move ? next_floor : floor_ff;
   assign rsp_car_dir   = sweep_ff;
   assign rsp_idle      = (up_ff | down_ff | pup_ff | pdn_ff) == '0;
   assign rsp_last      = dp_cmd.show_move ? status.at_target : 1'b1;

   always_comb begin
      up_in     = up_ff;
      down_in   = down_ff;
      pup_in    = pup_ff;
      pdn_in    = pdn_ff;
      floor_in  = floor_ff;
      target_in = target_ff;
      sweep_in  = sweep_ff;
      if (dp_cmd.load_req && req_in_range) begin
         if (!eff_dir) begin
            if (req_floor >= floor_ff) begin
               up_in = up_ff | req_bit;
            end else begin
               pup_in = pup_ff | req_bit;
            end
         end else begin
            if (req_floor <= floor_ff) begin
               down_in = down_ff | req_bit;
            end else begin
               pdn_in = pdn_ff | req_bit;
            end
         end
      end
      if (dp_cmd.do_step) begin
         if (!sweep_ff && (up_ff != '0)) begin
            target_in = low_t;
            up_in     = up_ff & ~(floor_set_type'(1) << low_t);
         end else if (sweep_ff && (down_ff != '0)) begin
            target_in = high_t;
            down_in   = down_ff & ~(floor_set_type'(1) << high_t);
         end else begin
            up_in    = up_ff | pup_ff;
            down_in  = down_ff | pdn_ff;
            pup_in   = '0;
            pdn_in   = '0;
            sweep_in = ~sweep_ff;
         end
      end
      if (dp_cmd.advance) begin
         floor_in = next_floor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff    <= '0;
         down_ff  <= '0;
         pup_ff   <= '0;
         pdn_ff   <= '0;
         floor_ff <= '0;
         sweep_ff <= 1'b0;
      end else begin
         up_ff    <= up_in;
         down_ff  <= down_in;
         pup_ff   <= pup_in;
         pdn_ff   <= pdn_in;
         floor_ff <= floor_in;
         sweep_ff <= sweep_in;
      end
      target_ff <= target_in;
   end

endmodule

[design/elevator_sweep_scheduler_core.sv]
// elevator sweep (look) scheduler top level: controller plus datapath
// depends on ess_pkg, ess_if, ess_ctrl, ess_datapath
// a request produces no result
// a step gives one result per floor passed (1 to 15), or a single status result
// when the car does not move; items are handled one at a time
// synchronous reset clears all request sets, puts the car at floor 0 sweeping up

module elevator_sweep_scheduler_core import ess_pkg::*; (
   input logic      clock,
   input logic      reset,
   ess_req_if.sink  req,
   ess_rsp_if.source rsp
);

   dp_cmd_type    dp_cmd;
   dp_status_type status;

   ess_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_cmd   (req.cmd),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .dp_cmd    (dp_cmd)
   );

   ess_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .dp_cmd        (dp_cmd),
      .req_cmd       (req.cmd),
      .req_floor     (req.floor),
      .req_dir       (req.dir),
      .status        (status),
      .rsp_car_floor (rsp.car_floor),
      .rsp_car_dir   (rsp.car_dir),
      .rsp_idle      (rsp.idle),
      .rsp_last      (rsp.last)
   );

endmodule
